/* src/lmq_pkg.sv */
// ----------------------------------------------------------------------------
// lmq_pkg
// Shared widths, operation codes and status codes of the linked queue manager.
// ----------------------------------------------------------------------------
package lmq_pkg;

	// Fixed field widths of the request and response transfers
	localparam int FUNC_W   = 2;
	localparam int QIDX_W   = 3;
	localparam int DATA_W   = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Default sizing of the cell pool and queue table
	localparam int DEF_POOL_CELLS  = 256;
	localparam int DEF_QUEUE_COUNT = 8;
	localparam int DEF_WORD_BITS   = 16;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUT   = 2'd0,
		FUNC_GET   = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_BUFFER = 2'd1,
		STATUS_EMPTY     = 2'd2
	} status_t;

endpackage

/* src/lmq_in_if.sv */
// ----------------------------------------------------------------------------
// lmq_in_if
// Request channel: operation, queue index and data word with valid/ready.
// ----------------------------------------------------------------------------
interface lmq_in_if;
	import lmq_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [QIDX_W-1:0] queue_index;
	logic [DATA_W-1:0] data_word;

	modport source (output valid, output func, output queue_index, output data_word,
		input ready);
	modport sink (input valid, input func, input queue_index, input data_word,
		output ready);

endinterface

/* src/lmq_out_if.sv */
// ----------------------------------------------------------------------------
// lmq_out_if
// Response channel: status, removed word and queue count with valid/ready.
// ----------------------------------------------------------------------------
interface lmq_out_if;
	import lmq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   read_word;
	logic [COUNT_W-1:0]  queue_count;

	modport source (output valid, output status, output read_word, output queue_count,
		input ready);
	modport sink (input valid, input status, input read_word, input queue_count,
		output ready);

endinterface

/* src/lmq_queue_table.sv */
// ----------------------------------------------------------------------------
// lmq_queue_table
// Head, tail and length of every queue; one read row, one write row.
// ----------------------------------------------------------------------------
module lmq_queue_table #(
	parameter int QUEUE_COUNT = 8,
	parameter int POOL_CELLS  = 256,
	parameter int QW          = 3,
	parameter int CW          = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [QW-1:0] rd_idx,
	output logic [CW-1:0] rd_head,
	output logic [CW-1:0] rd_tail,
	output logic [CW-1:0] rd_len,
	input  logic          we,
	input  logic [QW-1:0] wr_idx,
	input  logic [CW-1:0] wr_head,
	input  logic [CW-1:0] wr_tail,
	input  logic [CW-1:0] wr_len
);
	import lmq_pkg::*;

	localparam logic [CW-1:0] NIL = CW'(POOL_CELLS);

	logic [CW-1:0] head_q [QUEUE_COUNT];
	logic [CW-1:0] tail_q [QUEUE_COUNT];
	logic [CW-1:0] len_q  [QUEUE_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
				len_q[i]  <= '0;
			end
		end else if (we) begin
			head_q[wr_idx] <= wr_head;
			tail_q[wr_idx] <= wr_tail;
			len_q[wr_idx]  <= wr_len;
		end
	end

	assign rd_head = head_q[rd_idx];
	assign rd_tail = tail_q[rd_idx];
	assign rd_len  = len_q[rd_idx];

endmodule

/* src/lmq_cell_mem.sv */
// ----------------------------------------------------------------------------
// lmq_cell_mem
// Cell pool: link and word memories with registered reads. Cells below the
// fill mark have never left the initial free chain and read their reset link.
// ----------------------------------------------------------------------------
module lmq_cell_mem #(
	parameter int POOL_CELLS = 256,
	parameter int WORD_BITS  = 16,
	parameter int CW         = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [CW-1:0]        rd_ptr,
	output logic [CW-1:0]        link_rd,
	output logic [WORD_BITS-1:0] word_rd,
	input  logic                 link_we,
	input  logic [CW-1:0]        link_addr,
	input  logic [CW-1:0]        link_data,
	input  logic                 word_we,
	input  logic [CW-1:0]        word_addr,
	input  logic [WORD_BITS-1:0] word_data,
	input  logic                 pop_en,
	input  logic [CW-1:0]        pop_ptr
);
	import lmq_pkg::*;

	localparam int            AW  = $clog2(POOL_CELLS);
	localparam logic [CW-1:0] NIL = CW'(POOL_CELLS);

	logic [CW-1:0]        link_mem [POOL_CELLS];
	logic [WORD_BITS-1:0] word_mem [POOL_CELLS];

	logic [CW-1:0]        link_mem_rd_q;
	logic [WORD_BITS-1:0] word_mem_rd_q;
	logic [CW-1:0]        ptr_rd_q;
	logic                 fresh_rd_q;
	logic [CW-1:0]        mark_q;

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[AW'(link_addr)] <= link_data;
		end
		if (rd_en) begin
			link_mem_rd_q <= link_mem[AW'(rd_ptr)];
		end
	end

	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem[AW'(word_addr)] <= word_data;
		end
		if (rd_en) begin
			word_mem_rd_q <= word_mem[AW'(rd_ptr)];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ptr_rd_q   <= rd_ptr;
			fresh_rd_q <= (rd_ptr < mark_q);
		end
	end

	// Lowest cell ever popped; the initial chain is popped top down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= NIL;
		end else if (pop_en && (pop_ptr < mark_q)) begin
			mark_q <= pop_ptr;
		end
	end

	always_comb begin
		if (!fresh_rd_q) begin
			link_rd = link_mem_rd_q;
		end else if (ptr_rd_q == '0) begin
			link_rd = NIL;
		end else begin
			link_rd = ptr_rd_q - CW'(1);
		end
	end

	assign word_rd = word_mem_rd_q;

	a_link_wr_popped: assert property (@(posedge clk) disable iff (!arst_n)
		link_we |-> (link_addr >= mark_q) && (link_addr < NIL))
		else $error("link write to a cell that never left the free chain");

	a_pop_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |-> pop_ptr < NIL)
		else $error("pop of a null cell");

	a_mark_falls: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(mark_q) |-> mark_q < $past(mark_q))
		else $error("fill mark moved upward");

endmodule

/* src/linked_multi_queue_manager_top.sv */
// ----------------------------------------------------------------------------
// linked_multi_queue_manager_top
// Several FIFO queues over one shared pool of linked cells with a free list.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, queue_index, data_word
//   rsp      out  valid/ready    status, read_word, queue_count
//
// The accept edge registers the request and the queue row and launches the
// link/word memory read; the edge that completes stage 1 applies the update
// and loads the response register. The cell memories have a single read port,
// so an operation needs the link read back before its update.
// Reset clears all control state at once; no clearing pass is needed.
// A response waiting in the output register does not block the next request;
// a stalled response holds that request in stage 1, and req.ready stays low
// until the response transfer.
// ----------------------------------------------------------------------------
module linked_multi_queue_manager_top #(
	parameter int POOL_CELLS  = lmq_pkg::DEF_POOL_CELLS,
	parameter int QUEUE_COUNT = lmq_pkg::DEF_QUEUE_COUNT,
	parameter int WORD_BITS   = lmq_pkg::DEF_WORD_BITS
) (
	input logic       clk,
	input logic       arst_n,
	lmq_in_if.sink    req,
	lmq_out_if.source rsp
);
	import lmq_pkg::*;

	localparam int            CW  = $clog2(POOL_CELLS + 1);
	localparam int            QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam logic [CW-1:0] NIL = CW'(POOL_CELLS);

	function automatic logic in_pool(input logic [CW-1:0] p);
		return p < NIL;
	endfunction

	// Handshake
	logic accept;
	logic complete;

	// Stage 1: accepted request and its queue row
	logic                 s1_valid_q;
	logic [FUNC_W-1:0]    func_s1;
	logic [QW-1:0]        qsel_s1;
	logic                 qok_s1;
	logic [WORD_BITS-1:0] word_s1;
	logic [CW-1:0]        head_s1;
	logic [CW-1:0]        tail_s1;
	logic [CW-1:0]        len_s1;

	logic [CW-1:0] free_head_q;

	// Queue table read row
	logic [CW-1:0] qt_head;
	logic [CW-1:0] qt_tail;
	logic [CW-1:0] qt_len;

	// Cell memory
	logic [CW-1:0]        rd_ptr;
	logic [CW-1:0]        link_rd;
	logic [WORD_BITS-1:0] word_rd;

	// Update decision
	status_t              status_d;
	logic [WORD_BITS-1:0] rword_d;
	logic [CW-1:0]        count_d;
	logic                 qt_we;
	logic [CW-1:0]        new_head;
	logic [CW-1:0]        new_tail;
	logic [CW-1:0]        new_len;
	logic                 link_we;
	logic [CW-1:0]        link_addr;
	logic [CW-1:0]        link_data;
	logic                 word_we;
	logic                 pop_en;
	logic [CW-1:0]        free_head_d;

	// Response register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   read_word_q;
	logic [COUNT_W-1:0]  count_q;

	// Take a new request once stage 1 has drained
	assign req.ready = !s1_valid_q;
	assign accept    = req.valid && req.ready;
	// Finish stage 1 when the response register is free or being emptied
	assign complete  = s1_valid_q && (!out_valid_q || rsp.ready);

	lmq_queue_table #(
		.QUEUE_COUNT (QUEUE_COUNT),
		.POOL_CELLS  (POOL_CELLS),
		.QW          (QW),
		.CW          (CW)
	) u_qtab (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (QW'(req.queue_index)),
		.rd_head (qt_head),
		.rd_tail (qt_tail),
		.rd_len  (qt_len),
		.we      (qt_we && complete),
		.wr_idx  (qsel_s1),
		.wr_head (new_head),
		.wr_tail (new_tail),
		.wr_len  (new_len)
	);

	// A get reads the queue head cell; a put reads the free-list head cell
	assign rd_ptr = (req.func == FUNC_GET) ? qt_head : free_head_q;

	lmq_cell_mem #(
		.POOL_CELLS (POOL_CELLS),
		.WORD_BITS  (WORD_BITS),
		.CW         (CW)
	) u_cells (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_ptr    (rd_ptr),
		.link_rd   (link_rd),
		.word_rd   (word_rd),
		.link_we   (link_we && complete),
		.link_addr (link_addr),
		.link_data (link_data),
		.word_we   (word_we && complete),
		.word_addr (free_head_q),
		.word_data (word_s1),
		.pop_en    (pop_en && complete),
		.pop_ptr   (free_head_q)
	);

	// Register the request and its queue row at the accept edge
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			qsel_s1 <= QW'(req.queue_index);
			qok_s1  <= (int'(req.queue_index) < QUEUE_COUNT);
			word_s1 <= WORD_BITS'(req.data_word);
			head_s1 <= qt_head;
			tail_s1 <= qt_tail;
			len_s1  <= qt_len;
		end
	end

	// Apply one operation. A put leaves the new tail link stale: the tail
	// link is never followed until a later put, get or clear overwrites it.
	always_comb begin
		status_d    = STATUS_OK;
		rword_d     = '0;
		count_d     = '0;
		qt_we       = 1'b0;
		new_head    = head_s1;
		new_tail    = tail_s1;
		new_len     = len_s1;
		link_we     = 1'b0;
		link_addr   = tail_s1;
		link_data   = free_head_q;
		word_we     = 1'b0;
		pop_en      = 1'b0;
		free_head_d = free_head_q;
		if (qok_s1) begin
			unique case (func_s1)
				FUNC_PUT: begin
					if (!in_pool(free_head_q)) begin
						status_d = STATUS_NO_BUFFER;
					end else begin
						free_head_d = link_rd;
						word_we     = 1'b1;
						pop_en      = 1'b1;
						if ((len_s1 == '0) || !in_pool(tail_s1)) begin
							new_head = free_head_q;
						end else begin
							// Append behind the current tail
							link_we   = 1'b1;
							link_addr = tail_s1;
							link_data = free_head_q;
						end
						new_tail = free_head_q;
						new_len  = len_s1 + CW'(1);
						count_d  = new_len;
						qt_we    = 1'b1;
					end
				end
				FUNC_GET: begin
					if (!in_pool(head_s1)) begin
						status_d = STATUS_EMPTY;
					end else begin
						new_len = len_s1 - CW'(1);
						if (new_len == '0) begin
							new_head = NIL;
							new_tail = NIL;
						end else begin
							new_head = link_rd;
						end
						// Push the freed cell onto the free list
						link_we     = 1'b1;
						link_addr   = head_s1;
						link_data   = free_head_q;
						free_head_d = head_s1;
						rword_d     = word_rd;
						qt_we       = 1'b1;
					end
				end
				FUNC_CLEAR: begin
					if (len_s1 != '0) begin
						if (in_pool(tail_s1) && in_pool(head_s1)) begin
							// Splice the whole queue onto the free list front
							link_we     = 1'b1;
							link_addr   = tail_s1;
							link_data   = free_head_q;
							free_head_d = head_s1;
						end
						new_head = NIL;
						new_tail = NIL;
						new_len  = '0;
						qt_we    = 1'b1;
					end
				end
				default: begin
					// Unused code: no change, plain ok response
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			free_head_q <= CW'(POOL_CELLS - 1);
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (complete) begin
				s1_valid_q <= 1'b0;
			end
			if (complete) begin
				out_valid_q <= 1'b1;
				free_head_q <= free_head_d;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload; hold while the transfer stalls
	always_ff @(posedge clk) begin
		if (complete) begin
			status_q    <= status_d;
			read_word_q <= DATA_W'(rword_d);
			count_q     <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.read_word   = read_word_q;
	assign rsp.queue_count = count_q;

	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NIL)
		else $error("free-list head outside pool");

	a_head_len_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && qok_s1) |-> (in_pool(head_s1) == (len_s1 != '0)))
		else $error("queue head and length disagree");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && qok_s1) |-> len_s1 <= NIL)
		else $error("queue length above pool size");

	a_put_count: assert property (@(posedge clk) disable iff (!arst_n)
		(complete && qok_s1 && (func_s1 == FUNC_PUT) && in_pool(free_head_q))
		|=> (rsp.valid && (rsp.status == STATUS_OK)))
		else $error("successful put did not report ok");

endmodule
